// ===== rtl/core/pcmcv_pkg.sv =====
package pcmcv_pkg;

    localparam int EXP_W      = 13;
    localparam int SIG_W      = 53;
    localparam int PROD_W     = 77;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] FN_I16_TO_F = 3'd0;
    localparam logic [2:0] FN_F_TO_I16 = 3'd1;
    localparam logic [2:0] FN_I24_TO_F = 3'd2;
    localparam logic [2:0] FN_F_TO_I24 = 3'd3;
    localparam logic [2:0] FN_I32_TO_F = 3'd4;
    localparam logic [2:0] FN_F_TO_I32 = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FROM_I16 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FROM_I24 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FROM_I32 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TO_I24   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TO_I32   = 3'd4;

    localparam logic [31:0] GAIN_FROM_I16_RST = 32'h3800_0000;
    localparam logic [31:0] GAIN_FROM_I24_RST = 32'h3400_0000;
    localparam logic [31:0] GAIN_FROM_I32_RST = 32'h3000_0000;
    localparam logic [31:0] GAIN_TO_I24_RST   = 32'h4B00_0000;
    localparam logic [63:0] GAIN_TO_I32_RST   = 64'h41E0_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] sample_in;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] sample_out;
        logic        last_out;
    } out_item_t;

    // unpacked operand: value = sig / 2^52 * 2^exp, sig[52] set when finite nonzero
    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic                    inf;
        logic                    nan;
        logic signed [EXP_W-1:0] exp;
        logic [SIG_W-1:0]        sig;
    } op_t;

    typedef struct packed {
        op_t g_from16;
        op_t g_from24;
        op_t g_from32;
        op_t g_to24;
        op_t g_to32;
    } gains_t;

    typedef struct packed {
        logic [2:0] func;
        logic       last;
        op_t        a;
        op_t        b;
    } front_t;

    typedef struct packed {
        logic [2:0]              func;
        logic                    last;
        logic                    sign;
        logic                    zero;
        logic                    inf;
        logic                    nan;
        logic signed [EXP_W-1:0] exp;
        logic [PROD_W-1:0]       prod;
    } mul_t;

    localparam op_t OP_32768 = '{sign: 1'b0, zero: 1'b0, inf: 1'b0, nan: 1'b0,
                                 exp: 13'sd15, sig: {1'b1, 52'h0}};
    localparam op_t OP_32767 = '{sign: 1'b0, zero: 1'b0, inf: 1'b0, nan: 1'b0,
                                 exp: 13'sd14, sig: {15'h7FFF, 38'h0}};

    function automatic logic to_float_func(input logic [2:0] f);
        return (f == FN_I16_TO_F) || (f == FN_I24_TO_F) || (f == FN_I32_TO_F);
    endfunction

    // index of highest set bit, 0 when none
    function automatic logic [5:0] msb_pos64(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                p = 6'(i);
        end
        return p;
    endfunction

    function automatic op_t unpack_f32(input logic [31:0] b);
        op_t        o;
        logic [7:0] e;
        logic [22:0] m;
        logic [5:0] p;
        logic [23:0] s;
        e = b[30:23];
        m = b[22:0];
        p = msb_pos64({41'b0, m});
        s = {1'b0, m} << (6'd23 - p);
        o.sign = b[31];
        o.zero = 1'b0;
        o.inf  = 1'b0;
        o.nan  = 1'b0;
        o.exp  = $signed({5'b0, e}) - 13'sd127;
        o.sig  = {1'b1, m, 29'b0};
        if (e == 8'hFF)
        begin
            o.inf = (m == '0);
            o.nan = (m != '0);
        end
        else if (e == 8'h00)
        begin
            if (m == '0)
                o.zero = 1'b1;
            else
            begin
                o.sig = {s, 29'b0};
                o.exp = $signed({7'b0, p}) - 13'sd149;
            end
        end
        return o;
    endfunction

    function automatic op_t unpack_f64(input logic [63:0] b);
        op_t         o;
        logic [10:0] e;
        logic [51:0] m;
        logic [5:0]  p;
        logic [52:0] s;
        e = b[62:52];
        m = b[51:0];
        p = msb_pos64({12'b0, m});
        s = {1'b0, m} << (6'd52 - p);
        o.sign = b[63];
        o.zero = 1'b0;
        o.inf  = 1'b0;
        o.nan  = 1'b0;
        o.exp  = $signed({2'b0, e}) - 13'sd1023;
        o.sig  = {1'b1, m};
        if (e == 11'h7FF)
        begin
            o.inf = (m == '0);
            o.nan = (m != '0);
        end
        else if (e == 11'h000)
        begin
            if (m == '0)
                o.zero = 1'b1;
            else
            begin
                o.sig = s;
                o.exp = $signed({7'b0, p}) - 13'sd1074;
            end
        end
        return o;
    endfunction

endpackage

// ===== rtl/core/pcmcv_cfg.sv =====
module pcmcv_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcmcv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcmcv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pcmcv_pkg::gains_t                   gains
);
    import pcmcv_pkg::*;

    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    // gains are kept unpacked so the datapath never sees a subnormal operand
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_FROM_I16: gains_next.g_from16 = unpack_f32(cfg_data[31:0]);
                REG_GAIN_FROM_I24: gains_next.g_from24 = unpack_f32(cfg_data[31:0]);
                REG_GAIN_FROM_I32: gains_next.g_from32 = unpack_f32(cfg_data[31:0]);
                REG_GAIN_TO_I24:   gains_next.g_to24   = unpack_f32(cfg_data[31:0]);
                REG_GAIN_TO_I32:   gains_next.g_to32   = unpack_f64(cfg_data);
                default:           gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.g_from16 <= unpack_f32(GAIN_FROM_I16_RST);
            gains_reg.g_from24 <= unpack_f32(GAIN_FROM_I24_RST);
            gains_reg.g_from32 <= unpack_f32(GAIN_FROM_I32_RST);
            gains_reg.g_to24   <= unpack_f32(GAIN_TO_I24_RST);
            gains_reg.g_to32   <= unpack_f64(GAIN_TO_I32_RST);
        end
        else
            gains_reg <= gains_next;
    end

endmodule

// ===== rtl/core/pcmcv_front.sv =====
module pcmcv_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcmcv_pkg::in_item_t   in_item,
    input  pcmcv_pkg::gains_t     gains,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcmcv_pkg::front_t     out_data
);
    import pcmcv_pkg::*;

    typedef struct packed {
        logic [2:0]  func;
        logic        last;
        logic        isign;
        logic [31:0] imag;
        logic [4:0]  ipos;
        logic [31:0] cbits;
        op_t         b;
    } f1_t;

    logic     v0_reg, v1_reg, v2_reg;
    logic     rdy0, rdy1, rdy2;
    in_item_t s0_reg;
    f1_t      s1_reg, s1_next;
    front_t   s2_reg, s2_next;

    logic [31:0] ival;
    logic [31:0] xs;
    logic [5:0]  pos6;
    logic [31:0] norm;
    logic [24:0] rsum;
    logic        rup;

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign rdy0      = !v0_reg || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

    // stage 1: integer magnitude and leading one, float clamp, gain select
    always_comb
    begin
        xs = s0_reg.sample_in;
        unique case (s0_reg.func)
            FN_I16_TO_F: ival = {{16{xs[15]}}, xs[15:0]};
            FN_I24_TO_F: ival = {{8{xs[31]}}, xs[31:8]};
            default:     ival = xs;
        endcase
        s1_next.func  = s0_reg.func;
        s1_next.last  = s0_reg.last_in;
        s1_next.isign = ival[31];
        s1_next.imag  = ival[31] ? (~ival + 32'd1) : ival;
        pos6          = msb_pos64({32'b0, s1_next.imag});
        s1_next.ipos  = pos6[4:0];
        // clamp to [-1,1]; NaN becomes +0
        if (xs[30:23] == 8'hFF && xs[22:0] != '0)
            s1_next.cbits = '0;
        else if (xs[30:0] > 31'h3F80_0000)
            s1_next.cbits = {xs[31], 31'h3F80_0000};
        else
            s1_next.cbits = xs;
        unique case (s0_reg.func)
            FN_I16_TO_F: s1_next.b = gains.g_from16;
            FN_F_TO_I16: s1_next.b = s1_next.cbits[31] ? OP_32768 : OP_32767;
            FN_I24_TO_F: s1_next.b = gains.g_from24;
            FN_F_TO_I24: s1_next.b = gains.g_to24;
            FN_I32_TO_F: s1_next.b = gains.g_from32;
            FN_F_TO_I32: s1_next.b = gains.g_to32;
            default:     s1_next.b = gains.g_from16;
        endcase
    end

    // stage 2: int to float with round to nearest even, or unpack clamped float
    always_comb
    begin
        norm = s1_reg.imag << (5'd31 - s1_reg.ipos);
        rup  = norm[7] & ((|norm[6:0]) | norm[8]);
        rsum = {1'b0, norm[31:8]} + {24'b0, rup};
        s2_next.func = s1_reg.func;
        s2_next.last = s1_reg.last;
        s2_next.b    = s1_reg.b;
        if (to_float_func(s1_reg.func))
        begin
            s2_next.a.sign = s1_reg.isign;
            s2_next.a.zero = (s1_reg.imag == '0);
            s2_next.a.inf  = 1'b0;
            s2_next.a.nan  = 1'b0;
            s2_next.a.exp  = {8'b0, s1_reg.ipos} + {12'b0, rsum[24]};
            s2_next.a.sig  = rsum[24] ? {1'b1, 52'b0} : {rsum[23:0], 29'b0};
        end
        else
            s2_next.a = unpack_f32(s1_reg.cbits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
            s0_reg <= in_item;
        if (rdy1 && v0_reg)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
    end

endmodule

// ===== rtl/core/pcmcv_mul.sv =====
module pcmcv_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pcmcv_pkg::front_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pcmcv_pkg::mul_t     out_data
);
    import pcmcv_pkg::*;

    typedef struct packed {
        logic [2:0]              func;
        logic                    last;
        logic                    sign;
        logic                    zero;
        logic                    inf;
        logic                    nan;
        logic signed [EXP_W-1:0] exp;
        logic [49:0]             pp_lo;
        logic [50:0]             pp_hi;
    } m1_t;

    logic  v1_reg, v2_reg;
    logic  rdy1, rdy2;
    m1_t   s1_reg, s1_next;
    mul_t  s2_reg, s2_next;

    logic [23:0] a24;
    logic        anan;

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

    // 24 x 53 product split into two partial products
    always_comb
    begin
        a24  = in_data.a.sig[SIG_W-1:SIG_W-24];
        anan = in_data.a.nan || in_data.b.nan
            || (in_data.a.zero && in_data.b.inf) || (in_data.a.inf && in_data.b.zero);
        s1_next.func  = in_data.func;
        s1_next.last  = in_data.last;
        s1_next.sign  = in_data.a.sign ^ in_data.b.sign;
        s1_next.nan   = anan;
        s1_next.inf   = (in_data.a.inf || in_data.b.inf) && !anan;
        s1_next.zero  = (in_data.a.zero || in_data.b.zero) && !anan;
        s1_next.exp   = in_data.a.exp + in_data.b.exp;
        s1_next.pp_lo = a24 * in_data.b.sig[25:0];
        s1_next.pp_hi = a24 * in_data.b.sig[52:26];
    end

    always_comb
    begin
        s2_next.func = s1_reg.func;
        s2_next.last = s1_reg.last;
        s2_next.sign = s1_reg.sign;
        s2_next.zero = s1_reg.zero;
        s2_next.inf  = s1_reg.inf;
        s2_next.nan  = s1_reg.nan;
        s2_next.exp  = s1_reg.exp;
        s2_next.prod = {s1_reg.pp_hi, 26'b0} + {27'b0, s1_reg.pp_lo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
    end

endmodule

// ===== rtl/core/pcmcv_back.sv =====
module pcmcv_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcmcv_pkg::mul_t       in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcmcv_pkg::out_item_t  out_item
);
    import pcmcv_pkg::*;

    typedef struct packed {
        logic [2:0]              func;
        logic                    last;
        logic                    sign;
        logic                    zero;
        logic                    inf;
        logic                    nan;
        logic                    sub;
        logic                    dbl;
        logic signed [EXP_W-1:0] exp;
        logic [PROD_W-1:0]       m;
        logic                    lost;
    } b1_t;

    typedef struct packed {
        logic [2:0]              func;
        logic                    last;
        logic                    sign;
        logic                    zero;
        logic                    inf;
        logic                    nan;
        logic                    sub;
        logic signed [EXP_W-1:0] exp;
        logic [SIG_W-1:0]        sig;
    } b2_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        last;
        logic        sign;
        logic        sat;
        logic [31:0] fword;
        logic [31:0] q;
    } b3_t;

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      rdy1, rdy2, rdy3, rdy4;
    b1_t       s1_reg, s1_next;
    b2_t       s2_reg, s2_next;
    b3_t       s3_reg, s3_next;
    out_item_t out_reg, out_next;
    logic [2:0] out_func_reg;

    logic [PROD_W-1:0]       mn;
    logic signed [EXP_W-1:0] en;
    logic signed [EXP_W-1:0] dsr;
    logic [4:0]              ds;
    logic [53:0]             sum53;
    logic [24:0]             sum24;
    logic                    up53, up24;
    logic signed [EXP_W-1:0] eb;
    logic signed [EXP_W-1:0] shr;
    logic [32:0]             qsum;
    logic [31:0]             mag;
    logic [31:0]             hi;
    logic [31:0]             ival;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v4_reg;
    assign out_item  = out_reg;

    // stage 1: one-bit normalize, shift right into the float subnormal range
    always_comb
    begin
        if (in_data.prod[PROD_W-1])
        begin
            mn = in_data.prod;
            en = in_data.exp + 13'sd1;
        end
        else
        begin
            mn = in_data.prod << 1;
            en = in_data.exp;
        end
        dsr = -13'sd126 - en;
        s1_next.func = in_data.func;
        s1_next.last = in_data.last;
        s1_next.sign = in_data.sign;
        s1_next.zero = in_data.zero;
        s1_next.inf  = in_data.inf;
        s1_next.nan  = in_data.nan;
        s1_next.dbl  = (in_data.func == FN_F_TO_I32);
        s1_next.sub  = to_float_func(in_data.func) && (en < -13'sd126);
        s1_next.exp  = en;
        if (!s1_next.sub)
            ds = '0;
        else if (dsr > 13'sd26)
            ds = 5'd26;
        else
            ds = dsr[4:0];
        s1_next.m    = mn >> ds;
        s1_next.lost = |(mn & ~({PROD_W{1'b1}} << ds));
    end

    // stage 2: round to nearest even at 24 or 53 bits
    always_comb
    begin
        up53  = s1_reg.m[23] & ((|s1_reg.m[22:0]) | s1_reg.lost | s1_reg.m[24]);
        sum53 = {1'b0, s1_reg.m[76:24]} + {53'b0, up53};
        up24  = s1_reg.m[52] & ((|s1_reg.m[51:0]) | s1_reg.lost | s1_reg.m[53]);
        sum24 = {1'b0, s1_reg.m[76:53]} + {24'b0, up24};
        s2_next.func = s1_reg.func;
        s2_next.last = s1_reg.last;
        s2_next.sign = s1_reg.sign;
        s2_next.zero = s1_reg.zero;
        s2_next.inf  = s1_reg.inf;
        s2_next.nan  = s1_reg.nan;
        s2_next.sub  = s1_reg.sub;
        if (s1_reg.dbl)
        begin
            s2_next.exp = s1_reg.exp + {12'b0, sum53[53]};
            s2_next.sig = sum53[53] ? {1'b1, 52'b0} : sum53[52:0];
        end
        else
        begin
            s2_next.exp = s1_reg.exp + {12'b0, sum24[24]};
            s2_next.sig = sum24[24] ? {1'b1, 52'b0} : {sum24[23:0], 29'b0};
        end
    end

    // stage 3: pack float, or scale to integer with one fraction bit
    always_comb
    begin
        eb  = s2_reg.exp + 13'sd127;
        shr = 13'sd51 - s2_reg.exp;
        s3_next.func = s2_reg.func;
        s3_next.last = s2_reg.last;
        s3_next.sign = s2_reg.sign;
        if (s2_reg.nan)
            s3_next.fword = 32'h7FC0_0000;
        else if (s2_reg.inf)
            s3_next.fword = {s2_reg.sign, 8'hFF, 23'b0};
        else if (s2_reg.zero)
            s3_next.fword = {s2_reg.sign, 31'b0};
        else if (s2_reg.sub)
            s3_next.fword = {s2_reg.sign, 7'b0, s2_reg.sig[52], s2_reg.sig[51:29]};
        else if (eb > 13'sd254)
            s3_next.fword = {s2_reg.sign, 8'hFF, 23'b0};
        else
            s3_next.fword = {s2_reg.sign, eb[7:0], s2_reg.sig[51:29]};
        s3_next.sat = 1'b0;
        s3_next.q   = '0;
        if (s2_reg.nan || s2_reg.zero)
            s3_next.q = '0;
        else if (s2_reg.inf || s2_reg.exp >= 13'sd31)
            s3_next.sat = 1'b1;
        else if (s2_reg.exp >= -13'sd1)
            s3_next.q = 32'(s2_reg.sig >> shr[5:0]);
    end

    // stage 4: round half away from zero, saturate, place in output word
    always_comb
    begin
        qsum = {1'b0, s3_reg.q} + 33'd1;
        mag  = qsum[32:1];
        unique case (s3_reg.func)
            FN_F_TO_I16: hi = 32'd32767;
            FN_F_TO_I24: hi = 32'd8388607;
            default:     hi = 32'h7FFF_FFFF;
        endcase
        if (s3_reg.sat || mag > hi)
            ival = s3_reg.sign ? ~hi : hi;
        else
            ival = s3_reg.sign ? (~mag + 32'd1) : mag;
        out_next.last_out = s3_reg.last;
        unique case (s3_reg.func)
            FN_I16_TO_F, FN_I24_TO_F, FN_I32_TO_F: out_next.sample_out = s3_reg.fword;
            FN_F_TO_I16, FN_F_TO_I32:              out_next.sample_out = ival;
            FN_F_TO_I24:                           out_next.sample_out = {ival[23:0], 8'b0};
            default:                               out_next.sample_out = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
        if (rdy4 && v3_reg)
        begin
            out_reg      <= out_next;
            out_func_reg <= s3_reg.func;
        end
    end

`ifndef SYNTH
    a_round_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !s2_reg.zero && !s2_reg.inf && !s2_reg.nan && !s2_reg.sub
        |-> s2_reg.sig[SIG_W-1])
        else $error("rounded significand lost its leading one");

    a_i24_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && out_func_reg == FN_F_TO_I24 |-> out_reg.sample_out[7:0] == 8'h00)
        else $error("int24 result has nonzero low byte");

    a_i16_sext: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && out_func_reg == FN_F_TO_I16
        |-> out_reg.sample_out[31:15] == '0 || out_reg.sample_out[31:15] == '1)
        else $error("int16 result not sign extended");

    a_bad_func_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && out_func_reg > FN_F_TO_I32 |-> out_reg.sample_out == '0)
        else $error("unused function code gave nonzero sample");
`endif

endmodule

// ===== rtl/core/pcm_int_float_sample_converter.sv =====
// An accepted item passes through the front, multiplier and back-end stage registers to the output.
// Throughput: one item per cycle while out_stall is low; each pipeline stage advances when the
// stage after it is empty or moving, so bubbles are absorbed under stall.
// Reset: all stage valid bits clear and the gain registers return to their
// defaults (2^-15, 2^-23, 2^-31, 2^23 and 2^31).
module pcm_int_float_sample_converter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pcmcv_pkg::in_item_t                in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pcmcv_pkg::out_item_t               out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcmcv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcmcv_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcmcv_pkg::*;

    gains_t gains;
    front_t front_data;
    mul_t   mul_data;
    logic   front_ready, front_valid;
    logic   mul_ready, mul_valid;
    logic   back_ready;

    assign in_stall = !front_ready;

    pcmcv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    pcmcv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .in_item   (in_item),
        .gains     (gains),
        .out_valid (front_valid),
        .out_ready (mul_ready),
        .out_data  (front_data)
    );

    pcmcv_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (mul_ready),
        .in_data   (front_data),
        .out_valid (mul_valid),
        .out_ready (back_ready),
        .out_data  (mul_data)
    );

    pcmcv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (back_ready),
        .in_data   (mul_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_item  (out_item)
    );

`ifndef SYNTH
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");
`endif

endmodule

// ===== dv/pcm_int_float_sample_converter_test.sv =====
`timescale 1ns / 1ps

module pcm_int_float_sample_converter_test;
    import pcmcv_pkg::*;

    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_ONE = 32'h3F80_0000;
    localparam logic [31:0] F32_MINUS_ONE = 32'hBF80_0000;
    localparam logic [31:0] F32_32768 = 32'h4700_0000;
    localparam logic [31:0] F32_32767 = 32'h46FF_FE00;
    localparam int RANDOM_PER_PHASE = 95;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] sample;
        logic        last;
        bit          typed;
        logic [31:0] result;
    } vector_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the gain registers
    logic [31:0] gain_i16_f;
    logic [31:0] gain_i24_f;
    logic [31:0] gain_i32_f;
    logic [31:0] gain_f_i24;
    logic [63:0] gain_f_i32;

    out_item_t pending_results[$];
    int mismatches;
    int results_seen;
    int items_sent;
    int idle_cycles;
    int stall_max;

    pcm_int_float_sample_converter uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic real f32_value(input logic [31:0] b);
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, 52'b0});
        if (b[30:23] == 8'h00)
        begin
            if (b[31])
                return -(real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000));
            return real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        end
        return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'b0});
    endfunction

    // nearest-even rounding of a finite double to binary32, subnormals kept
    function automatic logic [31:0] round_to_f32(input real r);
        logic [63:0] d;
        logic [63:0] mant;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int e;
        int sh;
        d = $realtobits(r);
        if (d[62:0] == '0)
            return {d[63], 31'b0};
        e = int'(d[62:52]) - 1023;
        mant = {11'b0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            return {d[63], 31'b0};
        q = mant >> sh;
        rem = mant & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        if (e >= -126)
        begin
            if (q == (64'd1 << 24))
            begin
                q = q >> 1;
                e = e + 1;
            end
            if (e > 127)
                return {d[63], 8'hFF, 23'b0};
            return {d[63], 8'(e + 127), q[22:0]};
        end
        return {d[63], 31'(q)};
    endfunction

    function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_inf;
        logic b_inf;
        logic a_zero;
        logic b_zero;
        logic s;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        s = a[31] ^ b[31];
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            return F32_QNAN;
        if (a_inf || b_inf)
            return {s, 8'hFF, 23'b0};
        if (a_zero || b_zero)
            return {s, 31'b0};
        // product of two binary32 values is exact in double
        return round_to_f32(f32_value(a) * f32_value(b));
    endfunction

    function automatic logic [31:0] clamp_unit_f32(input logic [31:0] x);
        real r;
        if (x[30:23] == 8'hFF && x[22:0] != '0)
            return 32'h0;
        r = f32_value(x);
        if (r < -1.0)
            return F32_MINUS_ONE;
        if (r > 1.0)
            return F32_ONE;
        return x;
    endfunction

    function automatic longint round_saturate(input real s, input longint lo, input longint hi);
        longint t;
        real frac;
        if (s >= real'(hi))
            return hi;
        if (s <= real'(lo))
            return lo;
        t = longint'($rtoi(s));
        frac = s - real'(t);
        if (frac >= 0.5)
            t = t + 1;
        else if (frac <= -0.5)
            t = t - 1;
        if (t > hi)
            t = hi;
        if (t < lo)
            t = lo;
        return t;
    endfunction

    function automatic logic [31:0] convert_sample(input logic [2:0] func,
                                                   input logic [31:0] x);
        logic [31:0] c;
        logic [31:0] p;
        logic gain_nan;
        logic gain_inf;
        longint v;
        case (func)
            FN_I16_TO_F:
                return mul_f32(round_to_f32(real'(longint'($signed(x[15:0])))), gain_i16_f);
            FN_I24_TO_F:
                return mul_f32(round_to_f32(real'(longint'($signed(x[31:8])))), gain_i24_f);
            FN_I32_TO_F:
                return mul_f32(round_to_f32(real'(longint'($signed(x)))), gain_i32_f);
            FN_F_TO_I16:
            begin
                c = clamp_unit_f32(x);
                p = mul_f32(c, (f32_value(c) < 0.0) ? F32_32768 : F32_32767);
                v = round_saturate(f32_value(p), -32768, 32767);
                return 32'(v);
            end
            FN_F_TO_I24:
            begin
                p = mul_f32(clamp_unit_f32(x), gain_f_i24);
                if (p == F32_QNAN)
                    return 32'h0;
                v = round_saturate(f32_value(p), -8388608, 8388607);
                return {v[23:0], 8'h00};
            end
            FN_F_TO_I32:
            begin
                c = clamp_unit_f32(x);
                gain_nan = (gain_f_i32[62:52] == 11'h7FF) && (gain_f_i32[51:0] != '0);
                gain_inf = (gain_f_i32[62:52] == 11'h7FF) && (gain_f_i32[51:0] == '0);
                if (gain_nan || (gain_inf && c[30:0] == '0))
                    v = 0;
                else if (gain_inf)
                    v = (c[31] ^ gain_f_i32[63]) ? -64'sd2147483648 : 64'sd2147483647;
                else
                    v = round_saturate(f32_value(c) * $bitstoreal(gain_f_i32),
                                       -64'sd2147483648, 64'sd2147483647);
                return 32'(v);
            end
            default:
                return 32'h0;
        endcase
    endfunction

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_FROM_I16: gain_i16_f = value[31:0];
            REG_GAIN_FROM_I24: gain_i24_f = value[31:0];
            REG_GAIN_FROM_I32: gain_i32_f = value[31:0];
            REG_GAIN_TO_I24: gain_f_i24 = value[31:0];
            REG_GAIN_TO_I32: gain_f_i32 = value;
            default: ;
        endcase
    endtask

    // called at the edge where the previous item was taken, so the next one
    // (or the idle gap) is driven before the following edge
    task automatic send_sample(input logic [2:0] func, input logic [31:0] x, input logic last,
                               input bit typed, input logic [31:0] result);
        int gap;
        out_item_t exp_item;
        gap = $urandom_range(0, stall_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{func: func, sample_in: x, last_in: last};
        do
            @(posedge clk);
        while (in_stall);
        exp_item.sample_out = typed ? result : convert_sample(func, x);
        exp_item.last_out = last;
        pending_results.push_back(exp_item);
        items_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [31:0] random_float;
        logic [31:0] picks[9];
        picks = '{32'h0, 32'h8000_0000, F32_ONE, F32_MINUS_ONE, 32'h7F80_0000,
                  32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'hC2C8_0000};
        if ($urandom_range(0, 9) == 0)
            return picks[$urandom_range(0, 8)];
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return {1'($urandom), 8'($urandom_range(100, 127)), 23'($urandom)};
    endfunction

    function automatic logic [31:0] random_gain;
        return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    endfunction

    task automatic random_samples(input int count);
        logic [2:0] func;
        logic [31:0] x;
        for (int i = 0; i < count; i++)
        begin
            func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
            x = (func == FN_F_TO_I16 || func == FN_F_TO_I24 || func == FN_F_TO_I32)
                ? random_float() : $urandom;
            send_sample(func, x, 1'($urandom), 1'b0, 32'h0);
        end
    endtask

    // output side: random stall before each item
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected item: sample %h last %b",
                             out_item.sample_out, out_item.last_out);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.sample_out !== out_item.sample_out ||
                    want.last_out !== out_item.last_out)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected sample %h last %b, got sample %h last %b",
                                 want.sample_out, want.last_out,
                                 out_item.sample_out, out_item.last_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d items outstanding", pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        vector_t vectors[$];
        vectors = '{
            '{FN_F_TO_I16, F32_ONE, 1'b0, 1'b1, 32'h0000_7FFF},
            '{FN_F_TO_I16, F32_MINUS_ONE, 1'b1, 1'b1, 32'hFFFF_8000},
            '{FN_F_TO_I16, 32'h7FC0_0001, 1'b0, 1'b1, 32'h0},
            '{FN_F_TO_I16, 32'h7F80_0000, 1'b1, 1'b1, 32'h0000_7FFF},
            '{FN_F_TO_I16, 32'h4000_0000, 1'b0, 1'b1, 32'h0000_7FFF},
            '{FN_F_TO_I16, 32'h8000_0000, 1'b0, 1'b1, 32'h0},
            '{FN_F_TO_I16, 32'h3F00_0000, 1'b1, 1'b0, 32'h0},
            '{FN_I16_TO_F, 32'h0000_8000, 1'b0, 1'b1, F32_MINUS_ONE},
            '{FN_I16_TO_F, 32'hFFFF_7FFF, 1'b1, 1'b0, 32'h0},
            '{FN_I16_TO_F, 32'hABCD_0000, 1'b0, 1'b1, 32'h0},
            '{FN_I24_TO_F, 32'h8000_0000, 1'b1, 1'b1, F32_MINUS_ONE},
            '{FN_I24_TO_F, 32'h0000_00FF, 1'b0, 1'b1, 32'h0},
            '{FN_I24_TO_F, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
            '{FN_F_TO_I24, F32_ONE, 1'b1, 1'b1, 32'h7FFF_FF00},
            '{FN_F_TO_I24, F32_MINUS_ONE, 1'b0, 1'b1, 32'h8000_0000},
            '{FN_F_TO_I24, 32'hFF80_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{FN_I32_TO_F, 32'h8000_0000, 1'b1, 1'b1, F32_MINUS_ONE},
            '{FN_I32_TO_F, 32'h7FFF_FFFF, 1'b0, 1'b1, F32_ONE},
            '{FN_I32_TO_F, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
            '{FN_F_TO_I32, F32_ONE, 1'b1, 1'b1, 32'h7FFF_FFFF},
            '{FN_F_TO_I32, F32_MINUS_ONE, 1'b0, 1'b1, 32'h8000_0000},
            '{FN_F_TO_I32, 32'h0000_0001, 1'b0, 1'b1, 32'h0},
            '{FN_F_TO_I32, 32'hBEAA_AAAB, 1'b1, 1'b0, 32'h0},
            '{FN_SPARE_6, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
            '{FN_SPARE_7, 32'h1234_5678, 1'b0, 1'b1, 32'h0}
        };
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        stall_max = 4;
        gain_i16_f = GAIN_FROM_I16_RST;
        gain_i24_f = GAIN_FROM_I24_RST;
        gain_i32_f = GAIN_FROM_I32_RST;
        gain_f_i24 = GAIN_TO_I24_RST;
        gain_f_i32 = GAIN_TO_I32_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vectors[i])
            send_sample(vectors[i].func, vectors[i].sample, vectors[i].last,
                        vectors[i].typed, vectors[i].result);
        random_samples(RANDOM_PER_PHASE);
        drain();

        // random finite gains, upper data bits set to check masking
        write_gain(REG_GAIN_FROM_I16, {$urandom, random_gain()});
        write_gain(REG_GAIN_FROM_I24, {$urandom, random_gain()});
        write_gain(REG_GAIN_FROM_I32, {$urandom, random_gain()});
        write_gain(REG_GAIN_TO_I24, {$urandom, random_gain()});
        write_gain(REG_GAIN_TO_I32, {1'($urandom), 11'($urandom_range(1000, 1060)),
                                     20'($urandom), 32'($urandom)});
        random_samples(RANDOM_PER_PHASE);
        drain();

        // zero, infinite, NaN, subnormal and largest finite gains
        write_gain(REG_GAIN_FROM_I16, 64'h0);
        write_gain(REG_GAIN_FROM_I24, 64'hFFFF_FFFF_7F80_0000);
        write_gain(REG_GAIN_FROM_I32, 64'h7FC1_2345);
        write_gain(REG_GAIN_TO_I24, 64'h1);
        write_gain(REG_GAIN_TO_I32, 64'h7FEF_FFFF_FFFF_FFFF);
        random_samples(RANDOM_PER_PHASE / 2);
        drain();
        write_gain(REG_GAIN_FROM_I16, 64'hFFFF_FFFF);
        write_gain(REG_GAIN_FROM_I24, 64'h1);
        write_gain(REG_GAIN_FROM_I32, 64'h7F7F_FFFF);
        write_gain(REG_GAIN_TO_I24, 64'hFF80_0000);
        write_gain(REG_GAIN_TO_I32, 64'h1);
        write_gain(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        random_samples(RANDOM_PER_PHASE / 2);
        drain();
        write_gain(REG_GAIN_TO_I32, 64'h7FF0_0000_0000_0000);
        write_gain(REG_GAIN_TO_I24, 64'h7FC0_0000);
        random_samples(RANDOM_PER_PHASE / 4);
        drain();

        // defaults again, back to back on both sides
        stall_max = 0;
        write_gain(REG_GAIN_FROM_I16, GAIN_FROM_I16_RST);
        write_gain(REG_GAIN_FROM_I24, GAIN_FROM_I24_RST);
        write_gain(REG_GAIN_FROM_I32, GAIN_FROM_I32_RST);
        write_gain(REG_GAIN_TO_I24, GAIN_TO_I24_RST);
        write_gain(REG_GAIN_TO_I32, GAIN_TO_I32_RST);
        random_samples(RANDOM_PER_PHASE);
        drain();

        $display("%0d samples converted over all six directions and spare codes,", items_sent);
        $display("%0d results checked under default, random and extreme gains", results_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/pcmcv_pkg.sv
rtl/core/pcmcv_cfg.sv
rtl/core/pcmcv_front.sv
rtl/core/pcmcv_mul.sv
rtl/core/pcmcv_back.sv
rtl/core/pcm_int_float_sample_converter.sv
dv/pcm_int_float_sample_converter_test.sv
